FILE: hdl/tefs_pkg.sv
package tefs_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 7;
  localparam int OUT_IDX_W = 6;

  typedef enum logic [0:0] {
    REG_VECTOR_LENGTH = 1'b0,
    REG_KEEP_COUNT    = 1'b1
  } cfg_reg_e;

  // One element walking up the chain of cells
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] mag;
  } probe_t;

  // What a cell holds and hands down when results are drained
  typedef struct packed {
    logic              loaded;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] mag;
  } stored_t;

endpackage

FILE: hdl/topk_error_feedback_sparsifier.sv
// Error-feedback top-k sparsifier for signed Q16.16 vectors. Gradient items
// are taken one per cycle; each is added with saturation to the stored error
// of its position and enters a chain of MAX_LENGTH cells, walking up one cell
// per cycle, comparing against every earlier element, and settling in the
// first free cell with its rank. Once the vector closes (vector_length items,
// clamped to 1..MAX_LENGTH), the block waits for the last element to settle,
// then drains the chain toward cell 0 and emits one result per cycle while
// the output is not stalled, in index order, zeroing the elements outside the
// keep_count largest magnitudes (ties go to the lower index) and writing back
// the new error. A vector passes through loading, the walk of its last element
// up the chain, and emitting; while the chain settles and drains, no item is
// taken. The first item of the next vector is taken in the cycle after the
// last result enters the output register. The error store needs no clearing
// pass after reset.
module topk_error_feedback_sparsifier import tefs_pkg::*; #(
  parameter int MAX_LENGTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DATA_W-1:0]    grad_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_IDX_W-1:0] element_index_o,
  output logic [DATA_W-1:0]    sparse_value_o,
  output logic                 was_kept_o,
  output logic                 last_of_vector_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [0:0]           cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int IW = $clog2(MAX_LENGTH);
  localparam int NW = IW + 1;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_RANK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  state_e            st_q, st_d;
  logic [IW-1:0]     pos_q, pos_d;
  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     em_q, em_d;
  logic [CFG_W-1:0]  vlen_q;
  logic [CFG_W-1:0]  keep_q;
  logic [CFG_W-1:0]  len_eff;
  logic [CFG_W-1:0]  keep_eff;
  logic              in_acc;
  logic              close;
  logic              push;
  logic              kept;
  logic [DATA_W-1:0] err_rd;
  logic [DATA_W-1:0] eff;

  logic                 out_vld_q;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic [DATA_W-1:0]    out_val_q;
  logic                 out_kept_q;
  logic                 out_last_q;

  probe_t        probe_c [MAX_LENGTH+1];
  logic [IW-1:0] pcnt_c  [MAX_LENGTH+1];
  stored_t       hold_c  [MAX_LENGTH+1];
  logic [IW-1:0] hrank_c [MAX_LENGTH+1];

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q <= CFG_W'(64);
      keep_q <= CFG_W'(64);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_VECTOR_LENGTH: vlen_q <= cfg_data_i;
        REG_KEEP_COUNT:    keep_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = vlen_q;
    if (vlen_q == '0) begin
      len_eff = CFG_W'(1);
    end else if (vlen_q > CFG_W'(MAX_LENGTH)) begin
      len_eff = CFG_W'(MAX_LENGTH);
    end
    keep_eff = (keep_q == '0) ? CFG_W'(1) : keep_q;
  end

  // Control
  assign in_stall_o = (st_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign close      = (CFG_W'(pos_q) + CFG_W'(1)) >= len_eff;
  assign push       = (st_q == ST_EMIT) && (!out_vld_q || !out_stall_i);

  always_comb begin
    st_d  = st_q;
    pos_d = pos_q;
    n_d   = n_q;
    cnt_d = cnt_q;
    em_d  = em_q;
    case (st_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (close) begin
            n_d   = NW'(pos_q) + NW'(1);
            cnt_d = NW'(pos_q) + NW'(1);
            pos_d = '0;
            st_d  = ST_RANK;
          end else begin
            pos_d = pos_q + IW'(1);
          end
        end
      end
      ST_RANK: begin
        // hold until the last element has settled in its cell
        cnt_d = cnt_q - NW'(1);
        if (cnt_q == NW'(1)) begin
          em_d = '0;
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (push) begin
          em_d = em_q + IW'(1);
          if (NW'(em_q) + NW'(1) == n_q) begin
            st_d = ST_LOAD;
          end
        end
      end
      default: st_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_LOAD;
      pos_q <= '0;
      n_q   <= '0;
      cnt_q <= '0;
      em_q  <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      n_q   <= n_d;
      cnt_q <= cnt_d;
      em_q  <= em_d;
    end
  end

  // Error store: read ahead at the next load position, written as results leave
  assign kept = CFG_W'(hrank_c[0]) < keep_eff;

  tefs_err_store #(
    .DEPTH(MAX_LENGTH),
    .AW   (IW)
  ) u_err_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (push),
    .wr_addr_i(em_q),
    .wr_data_i(kept ? '0 : hold_c[0].value),
    .rd_addr_i(pos_d),
    .rd_data_o(err_rd)
  );

  assign eff = sat_add(grad_value_i, err_rd);

  // Chain of cells
  assign probe_c[0]          = '{valid: in_acc, value: eff, mag: magnitude(eff)};
  assign pcnt_c[0]           = '0;
  assign hold_c[MAX_LENGTH]  = '0;
  assign hrank_c[MAX_LENGTH] = '0;

  for (genvar k = 0; k < MAX_LENGTH; k++) begin : g_cell
    tefs_cell #(
      .RANK_W(IW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .probe_i    (probe_c[k]),
      .probe_cnt_i(pcnt_c[k]),
      .probe_o    (probe_c[k+1]),
      .probe_cnt_o(pcnt_c[k+1]),
      .shift_i    (push),
      .hold_i     (hold_c[k+1]),
      .hold_rank_i(hrank_c[k+1]),
      .hold_o     (hold_c[k]),
      .hold_rank_o(hrank_c[k])
    );
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_idx_q  <= OUT_IDX_W'(em_q);
      out_val_q  <= kept ? hold_c[0].value : '0;
      out_kept_q <= kept;
      out_last_q <= (NW'(em_q) + NW'(1) == n_q);
    end
  end

  assign out_valid_o      = out_vld_q;
  assign element_index_o  = out_idx_q;
  assign sparse_value_o   = out_val_q;
  assign was_kept_o       = out_kept_q;
  assign last_of_vector_o = out_last_q;

endmodule

FILE: hdl/tefs_cell.sv
module tefs_cell import tefs_pkg::*; #(
  parameter int RANK_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  probe_t            probe_i,
  input  logic [RANK_W-1:0] probe_cnt_i,
  output probe_t            probe_o,
  output logic [RANK_W-1:0] probe_cnt_o,
  input  logic              shift_i,
  input  stored_t           hold_i,
  input  logic [RANK_W-1:0] hold_rank_i,
  output stored_t           hold_o,
  output logic [RANK_W-1:0] hold_rank_o
);

  logic              pvld_q;
  logic [DATA_W-1:0] pval_q;
  logic [DATA_W-1:0] pmag_q;
  logic [RANK_W-1:0] cnt_q;
  logic              loaded_q;
  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] mag_q;
  logic [RANK_W-1:0] rank_q;
  logic              beats;

  // A probe always comes from a later index, so it needs a strictly larger
  // magnitude to beat the element held here.
  assign beats = pmag_q > mag_q;

  always_comb begin
    probe_o     = '{valid: pvld_q && loaded_q, value: pval_q, mag: pmag_q};
    probe_cnt_o = beats ? cnt_q : cnt_q + RANK_W'(1);
  end

  assign hold_o      = '{loaded: loaded_q, value: value_q, mag: mag_q};
  assign hold_rank_o = rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q   <= 1'b0;
      loaded_q <= 1'b0;
    end else begin
      pvld_q <= probe_i.valid;
      if (shift_i) begin
        loaded_q <= hold_i.loaded;
      end else if (pvld_q && !loaded_q) begin
        loaded_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pval_q <= probe_i.value;
    pmag_q <= probe_i.mag;
    cnt_q  <= probe_cnt_i;
    if (shift_i) begin
      value_q <= hold_i.value;
      mag_q   <= hold_i.mag;
      rank_q  <= hold_rank_i;
    end else if (pvld_q) begin
      if (loaded_q) begin
        if (beats) begin
          rank_q <= rank_q + RANK_W'(1);
        end
      end else begin
        // first free cell: settle here with the count gathered on the way
        value_q <= pval_q;
        mag_q   <= pmag_q;
        rank_q  <= cnt_q;
      end
    end
  end

endmodule

FILE: hdl/tefs_err_store.sv
module tefs_err_store import tefs_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rd_q;
  logic              rd_vld_q;
  logic              hit;

  assign hit = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (hit) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= hit || vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: verif/tefs_sparsity_checker.sv
`timescale 1ns / 1ps

module tefs_sparsity_checker import tefs_pkg::*; #(
  parameter int MAX_LENGTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [DATA_W-1:0]    grad_value_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [OUT_IDX_W-1:0] element_index_i,
  input  logic [DATA_W-1:0]    sparse_value_i,
  input  logic                 was_kept_i,
  input  logic                 last_of_vector_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [0:0]           cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic [DATA_W-1:0]    value;
    logic                 kept;
    logic                 last;
  } sparse_elem_t;

  sparse_elem_t    expected_elems[$];
  logic [DATA_W-1:0] error_mem [MAX_LENGTH];
  logic [DATA_W-1:0] eff_mem   [MAX_LENGTH];
  logic [CFG_W-1:0]  length_reg;
  logic [CFG_W-1:0]  keep_reg;
  int                fill_pos;
  int                mismatches = 0;
  int                pending_q  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_q;

  function automatic logic [DATA_W-1:0] sat_sum(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] s;
    s = a + b;
    if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1]) begin
      s = a[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s;
  endfunction

  // -2^31 maps to 2^31, which still fits as unsigned
  function automatic logic [DATA_W-1:0] mag_of(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    $display("%0t sparsifier mismatch on %s: got %0h, expected %0h", $realtime, what, got,
             want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int           len;
    int           keep;
    int           pos;
    int           n;
    int           rank;
    logic [DATA_W-1:0] mi;
    logic [DATA_W-1:0] mj;
    sparse_elem_t got;
    sparse_elem_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LENGTH; i++) begin
        error_mem[i] = '0;
        eff_mem[i]   = '0;
      end
      fill_pos   = 0;
      length_reg = CFG_W'(64);
      keep_reg   = CFG_W'(64);
      expected_elems.delete();
      pending_q  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{element_index_i, sparse_value_i, was_kept_i, last_of_vector_i};
        if (expected_elems.size() == 0) begin
          flag_mismatch("unexpected result, index", DATA_W'(got.index), '0);
        end else begin
          want = expected_elems.pop_front();
          if (got.index !== want.index)
            flag_mismatch("element_index", DATA_W'(got.index), DATA_W'(want.index));
          if (got.value !== want.value)
            flag_mismatch("sparse_value", got.value, want.value);
          if (got.kept !== want.kept)
            flag_mismatch("was_kept", DATA_W'(got.kept), DATA_W'(want.kept));
          if (got.last !== want.last)
            flag_mismatch("last_of_vector", DATA_W'(got.last), DATA_W'(want.last));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_VECTOR_LENGTH) length_reg = cfg_data_i;
        else if (cfg_index_i == REG_KEEP_COUNT) keep_reg = cfg_data_i;
      end

      if (in_valid_i && !in_stall_i) begin
        len = int'(length_reg);
        if (len < 1) len = 1;
        if (len > MAX_LENGTH) len = MAX_LENGTH;
        pos = (fill_pos >= MAX_LENGTH) ? MAX_LENGTH - 1 : fill_pos;
        eff_mem[pos] = sat_sum(grad_value_i, error_mem[pos]);
        n = pos + 1;
        if (n < len) begin
          fill_pos = n;
        end else begin
          keep = int'(keep_reg);
          if (keep < 1) keep = 1;
          if (keep > n) keep = n;
          // rank by magnitude, lower index wins a tie
          for (int i = 0; i < n; i++) begin
            mi   = mag_of(eff_mem[i]);
            rank = 0;
            for (int j = 0; j < n; j++) begin
              mj = mag_of(eff_mem[j]);
              if (mj > mi || (mj == mi && j < i)) rank++;
            end
            want.index = OUT_IDX_W'(i);
            want.kept  = (rank < keep);
            want.value = want.kept ? eff_mem[i] : '0;
            want.last  = (i + 1 == n);
            expected_elems.push_back(want);
          end
          for (int i = 0; i < n; i++) begin
            error_mem[i] = expected_elems[expected_elems.size() - n + i].kept ? '0 : eff_mem[i];
          end
          fill_pos = 0;
        end
      end
      pending_q = expected_elems.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb import tefs_pkg::*;;

  localparam int MAX_LEN    = 64;
  localparam int HOLD_OFF   = 3 * MAX_LEN + 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_ITEMS = 380;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [DATA_W-1:0]    grad_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OUT_IDX_W-1:0] element_index_o;
  logic [DATA_W-1:0]    sparse_value_o;
  logic                 was_kept_o;
  logic                 last_of_vector_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [0:0]           cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  logic                 tx_burst = 1'b0;
  logic                 rx_burst = 1'b0;
  logic                 rx_took = 1'b0;
  int                   rx_wait = 0;
  logic [DATA_W-1:0]    last_grad = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  topk_error_feedback_sparsifier #(.MAX_LENGTH(MAX_LEN)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .grad_value_i    (grad_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_index_o (element_index_o),
    .sparse_value_o  (sparse_value_o),
    .was_kept_o      (was_kept_o),
    .last_of_vector_o(last_of_vector_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  tefs_sparsity_checker #(.MAX_LENGTH(MAX_LEN)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .grad_value_i    (grad_value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_index_i (element_index_o),
    .sparse_value_i  (sparse_value_o),
    .was_kept_i      (was_kept_o),
    .last_of_vector_i(last_of_vector_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    rx_took <= out_valid_o && !out_stall_i;
    if (cycles == CYCLE_CAP) begin
      $display("topk_error_feedback_sparsifier regression: fail");
      $finish;
    end
  end

  // Receiver: draw a fresh stall after every taken item, sometimes run calm
  always @(negedge clk_i) begin
    if (rx_took) begin
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
    end
    if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Called and returns at a falling edge; valid stays up across back-to-back items
  task automatic push_grad(input logic [DATA_W-1:0] v);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    grad_value_i <= v;
    last_grad     = v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input int len, input int keep);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_VECTOR_LENGTH;
    cfg_data_i  <= CFG_W'(len);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i <= REG_KEEP_COUNT;
    cfg_data_i  <= CFG_W'(keep);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, drain every expected item, then give the block time to go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (HOLD_OFF) @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_grad();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4:    v = DATA_W'($urandom_range(0, 2000)) - DATA_W'(1000);
      5:       v = last_grad;
      6:       v = ~last_grad + 1'b1;
      7: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = $urandom_range(0, 1) ? 32'h7fff_0000 + $urandom_range(0, 65535)
                                        : 32'h8000_0000 + $urandom_range(0, 65535);
    endcase
    return v;
  endfunction

  initial begin
    int sent;
    int len_cfg;
    int keep_cfg;
    int eff_len;
    int nvec;
    int part;
    sent = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Saturated extremes kept, small pair dropped into the error
    program_regs(4, 2);
    push_grad(32'h7fff_ffff);
    push_grad(32'h8000_0000);
    push_grad(32'h0000_0005);
    push_grad(32'hffff_fffb);
    // Stored error pushes these past the rails
    push_grad(32'h0000_0000);
    push_grad(32'h0000_0000);
    push_grad(32'h7fff_ffff);
    push_grad(32'h8000_0000);
    // Equal magnitudes of both signs: lower index wins
    push_grad(32'h0000_0009);
    push_grad(32'hffff_fff7);
    push_grad(32'h0000_0009);
    push_grad(32'h0000_0003);
    settle();
    // Zero length and zero keep act as one
    program_regs(0, 0);
    push_grad(32'h8000_0000);
    push_grad(32'h0000_0001);
    settle();
    // Lower the length below what is already loaded
    program_regs(8, 127);
    repeat (5) push_grad(pick_grad());
    settle();
    program_regs(3, 127);
    push_grad(pick_grad());
    settle();
    program_regs(2, 1);
    push_grad(32'hffff_ffff);
    push_grad(32'h0000_0001);
    settle();

    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       len_cfg = 0;
        1:       len_cfg = MAX_LEN;
        2:       len_cfg = $urandom_range(MAX_LEN + 1, 127);
        3, 4:    len_cfg = 1;
        default: len_cfg = $urandom_range(2, 12);
      endcase
      eff_len = (len_cfg < 1) ? 1 : (len_cfg > MAX_LEN) ? MAX_LEN : len_cfg;
      case ($urandom_range(0, 7))
        0:       keep_cfg = 0;
        1:       keep_cfg = $urandom_range(MAX_LEN + 1, 127);
        2:       keep_cfg = 1;
        3:       keep_cfg = eff_len;
        default: keep_cfg = $urandom_range(1, eff_len);
      endcase
      program_regs(len_cfg, keep_cfg);
      nvec = (eff_len > 16) ? 1 : $urandom_range(1, 4);
      repeat (nvec) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        repeat (eff_len) push_grad(pick_grad());
        sent += eff_len;
      end
      // Sometimes leave a vector half loaded and cut the length under it
      if (eff_len >= 3 && $urandom_range(0, 5) == 0) begin
        part = $urandom_range(1, eff_len - 1);
        repeat (part) push_grad(pick_grad());
        settle();
        program_regs($urandom_range(0, part), $urandom_range(0, 127));
        push_grad(pick_grad());
        sent += part + 1;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("topk_error_feedback_sparsifier regression: pass");
    end else begin
      $display("topk_error_feedback_sparsifier regression: fail");
    end
    $finish;
  end

endmodule
